### sv/obbsat_pkg.sv
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared types and constants for the 2D oriented box overlap test: transfer
// payloads, fixed-point scale and separating axis codes.
// ----------------------------------------------------------------------------
package obbsat_pkg;

  // Fraction bits of the rotation cosine/sine (Q1.14)
  localparam int TRIG_FRAC_BITS = 14;

  // Axes tested per pair: A axis 0, A axis 1, B axis 0, B axis 1
  localparam int NUM_AXES = 4;

  // Separating axis codes
  localparam logic [2:0] AXIS_A0   = 3'd0;
  localparam logic [2:0] AXIS_A1   = 3'd1;
  localparam logic [2:0] AXIS_B0   = 3'd2;
  localparam logic [2:0] AXIS_B1   = 3'd3;
  localparam logic [2:0] AXIS_NONE = 3'd4;

  // One box pair: centres Q15.16 signed, half extents Q15.16, trig Q1.14
  typedef struct packed {
    logic signed [31:0] a_centre_x;
    logic signed [31:0] a_centre_y;
    logic        [30:0] a_half_x;
    logic        [30:0] a_half_y;
    logic signed [15:0] a_cos;
    logic signed [15:0] a_sin;
    logic signed [31:0] b_centre_x;
    logic signed [31:0] b_centre_y;
    logic        [30:0] b_half_x;
    logic        [30:0] b_half_y;
    logic signed [15:0] b_cos;
    logic signed [15:0] b_sin;
  } obbsat_in_t;

  // Test result
  typedef struct packed {
    logic       overlap;
    logic [2:0] separating_axis;
  } obbsat_out_t;

endpackage

### sv/obbsat_in_if.sv
// ----------------------------------------------------------------------------
// obbsat_in_if
// Valid/ready channel carrying one box pair per transfer.
// ----------------------------------------------------------------------------
interface obbsat_in_if import obbsat_pkg::*; ();

  logic       valid;
  logic       ready;
  obbsat_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/obbsat_out_if.sv
// ----------------------------------------------------------------------------
// obbsat_out_if
// Valid/ready channel carrying one overlap result per transfer.
// ----------------------------------------------------------------------------
interface obbsat_out_if import obbsat_pkg::*; ();

  logic        valid;
  logic        ready;
  obbsat_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/obb_overlap_test_2d_unit.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_unit
// Separating axis overlap test for two oriented boxes in the plane.
// ----------------------------------------------------------------------------
// Takes one box pair per transfer and returns one result per pair, in order.
// Each pair goes through a seven-stage pipeline (centre difference, products,
// sums and magnitudes, radius products, partial sums, compare, encode), and a
// new pair can be accepted every cycle unless a stalled output has backed up
// the pipeline. The four axes are evaluated in parallel lanes and the first
// separating one in the order A0, A1, B0, B1 is reported. The test is exact:
// an axis separates only when the projected radius sum is strictly below the
// projected centre distance, so touching boxes overlap. Each stage holds its
// own valid bit and advances whenever the stage after it is free, so a
// stalled output only backs up the occupied stages.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d_unit import obbsat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  obbsat_in_if.sink           boxes,
  obbsat_out_if.source        result
);

  localparam int NUM_STAGES = 7;

  // --------------------------------------------------------------------------
  // Stage control: valid per stage, advance when the next slot frees up
  // --------------------------------------------------------------------------
  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] vld_in;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld[NUM_STAGES] || result.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in       = {vld[NUM_STAGES-1:1], boxes.valid};
  assign boxes.ready  = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: centre difference, axis vectors, half extents
  // --------------------------------------------------------------------------
  logic signed [32:0] s1_dx;
  logic signed [32:0] s1_dy;
  logic signed [16:0] s1_ux [NUM_AXES];
  logic signed [16:0] s1_uy [NUM_AXES];
  logic        [30:0] s1_h  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dx <= {boxes.data.a_centre_x[31], boxes.data.a_centre_x}
             - {boxes.data.b_centre_x[31], boxes.data.b_centre_x};
      s1_dy <= {boxes.data.a_centre_y[31], boxes.data.a_centre_y}
             - {boxes.data.b_centre_y[31], boxes.data.b_centre_y};
      // axis 0 = (c, -s), axis 1 = (s, c)
      s1_ux[0] <= {boxes.data.a_cos[15], boxes.data.a_cos};
      s1_uy[0] <= -{boxes.data.a_sin[15], boxes.data.a_sin};
      s1_ux[1] <= {boxes.data.a_sin[15], boxes.data.a_sin};
      s1_uy[1] <= {boxes.data.a_cos[15], boxes.data.a_cos};
      s1_ux[2] <= {boxes.data.b_cos[15], boxes.data.b_cos};
      s1_uy[2] <= -{boxes.data.b_sin[15], boxes.data.b_sin};
      s1_ux[3] <= {boxes.data.b_sin[15], boxes.data.b_sin};
      s1_uy[3] <= {boxes.data.b_cos[15], boxes.data.b_cos};
      // half extents paired with the box axes above
      s1_h[0] <= boxes.data.a_half_x;
      s1_h[1] <= boxes.data.a_half_y;
      s1_h[2] <= boxes.data.b_half_x;
      s1_h[3] <= boxes.data.b_half_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products for centre projection and axis-to-axis dots
  // --------------------------------------------------------------------------
  logic signed [49:0] s2_dpx [NUM_AXES];
  logic signed [49:0] s2_dpy [NUM_AXES];
  logic signed [33:0] s2_tpx [NUM_AXES][NUM_AXES];
  logic signed [33:0] s2_tpy [NUM_AXES][NUM_AXES];
  logic        [30:0] s2_h   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s2_dpx[k] <= s1_dx * s1_ux[k];
        s2_dpy[k] <= s1_dy * s1_uy[k];
        for (int j = 0; j < NUM_AXES; j++) begin
          s2_tpx[k][j] <= s1_ux[j] * s1_ux[k];
          s2_tpy[k][j] <= s1_uy[j] * s1_uy[k];
        end
      end
      s2_h <= s1_h;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: dot sums and magnitudes
  // --------------------------------------------------------------------------
  logic signed [50:0] s3_dsum [NUM_AXES];
  logic signed [34:0] s3_tsum [NUM_AXES][NUM_AXES];
  logic        [50:0] s3_dabs [NUM_AXES];
  logic        [34:0] s3_tabs [NUM_AXES][NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      s3_dsum[k] = 51'(s2_dpx[k]) + 51'(s2_dpy[k]);
      s3_dabs[k] = s3_dsum[k][50] ? 51'(-s3_dsum[k]) : 51'(s3_dsum[k]);
      for (int j = 0; j < NUM_AXES; j++) begin
        s3_tsum[k][j] = 35'(s2_tpx[k][j]) + 35'(s2_tpy[k][j]);
        s3_tabs[k][j] = s3_tsum[k][j][34] ? 35'(-s3_tsum[k][j]) : 35'(s3_tsum[k][j]);
      end
    end
  end

  // distance magnitude stays below 2^49, trig dot magnitude at most 2^31
  logic [48:0] s3_dmag [NUM_AXES];
  logic [31:0] s3_tmag [NUM_AXES][NUM_AXES];
  logic [30:0] s3_h    [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s3_dmag[k] <= s3_dabs[k][48:0];
        for (int j = 0; j < NUM_AXES; j++) begin
          s3_tmag[k][j] <= s3_tabs[k][j][31:0];
        end
      end
      s3_h <= s2_h;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: radius terms half * |axis_j . axis_k|, distance to radius scale
  // --------------------------------------------------------------------------
  logic [62:0] s4_rp   [NUM_AXES][NUM_AXES];
  logic [63:0] s4_dist [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s4_dist[k] <= 64'(s3_dmag[k]) << TRIG_FRAC_BITS;
        for (int j = 0; j < NUM_AXES; j++) begin
          s4_rp[k][j] <= s3_h[j] * s3_tmag[k][j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: per-box radius sums
  // --------------------------------------------------------------------------
  logic [63:0] s5_ra   [NUM_AXES];
  logic [63:0] s5_rb   [NUM_AXES];
  logic [63:0] s5_dist [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s5_ra[k] <= 64'(s4_rp[k][0]) + 64'(s4_rp[k][1]);
        s5_rb[k] <= 64'(s4_rp[k][2]) + 64'(s4_rp[k][3]);
      end
      s5_dist <= s4_dist;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: total radius against distance, strict less-than separates
  // --------------------------------------------------------------------------
  logic [63:0]         s6_rsum [NUM_AXES];
  logic [NUM_AXES-1:0] s6_sep;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      s6_rsum[k] = s5_ra[k] + s5_rb[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s6_sep[k] <= s6_rsum[k] < s5_dist[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: first separating axis into the output register
  // --------------------------------------------------------------------------
  obbsat_out_t res_next;
  obbsat_out_t res;

  always_comb begin
    priority if (s6_sep[0]) begin
      res_next.separating_axis = AXIS_A0;
    end else if (s6_sep[1]) begin
      res_next.separating_axis = AXIS_A1;
    end else if (s6_sep[2]) begin
      res_next.separating_axis = AXIS_B0;
    end else if (s6_sep[3]) begin
      res_next.separating_axis = AXIS_B1;
    end else begin
      res_next.separating_axis = AXIS_NONE;
    end
    res_next.overlap = !(|s6_sep);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      res <= res_next;
    end
  end

  assign result.valid = vld[NUM_STAGES];
  assign result.data  = res;

endmodule

### tb/sv/obb_overlap_test_2d_unit_tb.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_unit_tb
// Self-checking bench for the 2D oriented box overlap unit. Box pairs go in
// on the input channel, with directed corner cases first and then a random
// mix of nearby rotated boxes, exactly touching boxes and raw bit patterns.
// An exact separating axis calculation predicts each verdict, and the
// verdicts are compared in order. Both channels idle at random, and the
// result side holds off once for a long stretch so that the pipeline fills.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d_unit_tb;
  import obbsat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      RANDOM_PAIRS  = 500;
  localparam int      CYCLE_LIMIT   = 500000;
  localparam int      DRAIN_CYCLES  = 20;
  localparam int      MAX_REPORTS   = 10;
  localparam longint  ONE           = 65536;   // 1.0 in Q15.16
  localparam longint  UNIT          = 16384;   // 1.0 in Q1.14

  // Predicts the verdict of each accepted pair and checks verdicts in order
  class overlap_tracker;
    obbsat_out_t pending_verdicts[$];
    int          mismatches;

    // |x0*x1 + y0*y1|, exact in 64 bits for these operand ranges
    function logic [63:0] mag_dot(longint x0, longint y0, longint x1, longint y1);
      longint sum;
      sum = x0 * x1 + y0 * y1;
      return (sum < 0) ? 64'(-sum) : 64'(sum);
    endfunction

    // Projected radius of a box with half extents (hx, hy) onto axis (ux, uy)
    function logic [63:0] box_reach(logic [63:0] hx, logic [63:0] hy, longint c,
                                    longint s, longint ux, longint uy);
      return hx * mag_dot(c, -s, ux, uy) + hy * mag_dot(s, c, ux, uy);
    endfunction

    function obbsat_out_t predict_verdict(obbsat_in_t p);
      obbsat_out_t verdict;
      longint      dx, dy, ac, as, bc, bs;
      longint      ux[NUM_AXES];
      longint      uy[NUM_AXES];
      logic [2:0]  code[NUM_AXES];
      logic [63:0] ahx, ahy, bhx, bhy, proj_gap, rsum;
      dx  = longint'($signed(p.a_centre_x)) - longint'($signed(p.b_centre_x));
      dy  = longint'($signed(p.a_centre_y)) - longint'($signed(p.b_centre_y));
      ac  = longint'($signed(p.a_cos));
      as  = longint'($signed(p.a_sin));
      bc  = longint'($signed(p.b_cos));
      bs  = longint'($signed(p.b_sin));
      ahx = {33'b0, p.a_half_x};
      ahy = {33'b0, p.a_half_y};
      bhx = {33'b0, p.b_half_x};
      bhy = {33'b0, p.b_half_y};
      // Axis columns (c,-s) and (s,c) of each box, in test order
      ux[0] = ac;  uy[0] = -as;  code[0] = AXIS_A0;
      ux[1] = as;  uy[1] = ac;   code[1] = AXIS_A1;
      ux[2] = bc;  uy[2] = -bs;  code[2] = AXIS_B0;
      ux[3] = bs;  uy[3] = bc;   code[3] = AXIS_B1;
      verdict.overlap         = 1'b1;
      verdict.separating_axis = AXIS_NONE;
      for (int k = NUM_AXES - 1; k >= 0; k--) begin
        // Strict compare: touching boxes overlap
        proj_gap = mag_dot(dx, dy, ux[k], uy[k]) << TRIG_FRAC_BITS;
        rsum = box_reach(ahx, ahy, ac, as, ux[k], uy[k]) +
               box_reach(bhx, bhy, bc, bs, ux[k], uy[k]);
        if (rsum < proj_gap) begin
          verdict.overlap         = 1'b0;
          verdict.separating_axis = code[k];
        end
      end
      return verdict;
    endfunction

    function void note_pair(obbsat_in_t p);
      pending_verdicts.push_back(predict_verdict(p));
    endfunction

    function void check_verdict(obbsat_out_t got);
      obbsat_out_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: overlap=%0d axis=%0d", $realtime,
                   got.overlap, got.separating_axis);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.overlap !== want.overlap || got.separating_axis !== want.separating_axis) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch: expected overlap=%0d axis=%0d, got overlap=%0d axis=%0d",
                   $realtime, want.overlap, want.separating_axis, got.overlap,
                   got.separating_axis);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   sender_steady;

  obbsat_in_if  boxes_if ();
  obbsat_out_if result_if ();

  overlap_tracker tracker = new();

  obb_overlap_test_2d_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .boxes  (boxes_if),
    .result (result_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check every accepted verdict
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      tracker.check_verdict(result_if.data);
  end

  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic obbsat_in_t box_pair(longint acx, longint acy, longint ahx,
                                          longint ahy, longint ac, longint as,
                                          longint bcx, longint bcy, longint bhx,
                                          longint bhy, longint bc, longint bs);
    obbsat_in_t p;
    p.a_centre_x = 32'(acx);  p.a_centre_y = 32'(acy);
    p.a_half_x   = 31'(ahx);  p.a_half_y   = 31'(ahy);
    p.a_cos      = 16'(ac);   p.a_sin      = 16'(as);
    p.b_centre_x = 32'(bcx);  p.b_centre_y = 32'(bcy);
    p.b_half_x   = 31'(bhx);  p.b_half_y   = 31'(bhy);
    p.b_cos      = 16'(bc);   p.b_sin      = 16'(bs);
    return p;
  endfunction

  // Rounded Q1.14 cosine and sine of an angle in tenths of a degree
  function automatic void unit_trig(input int tenths, output longint c, output longint s);
    real th, cr, sr;
    th = tenths * 3.14159265358979 / 1800.0;
    cr = $cos(th) * 16384.0;
    sr = $sin(th) * 16384.0;
    c  = $rtoi(cr >= 0.0 ? cr + 0.5 : cr - 0.5);
    s  = $rtoi(sr >= 0.0 ? sr + 0.5 : sr - 0.5);
  endfunction

  // Quarter-turn rotations keep the box axes on the coordinate axes
  function automatic void quarter_trig(input int rot, output longint c, output longint s);
    case (rot)
      0:       begin c = UNIT;  s = 0;     end
      1:       begin c = 0;     s = UNIT;  end
      2:       begin c = -UNIT; s = 0;     end
      default: begin c = 0;     s = -UNIT; end
    endcase
  endfunction

  // Offer one pair at the falling edge and hold it until transferred
  task automatic send_pair(input obbsat_in_t p);
    int gap;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      boxes_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    boxes_if.data  = p;
    boxes_if.valid = 1'b1;
    do @(posedge clk); while (!boxes_if.ready);
    tracker.note_pair(p);
    @(negedge clk);
  endtask

  // Result side: a free-running start, one long hold-off, then random stalls
  initial begin
    int hold;
    result_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    result_if.ready = 1'b1;
    repeat (60) @(negedge clk);
    // Long hold-off so the pipeline fills and the input stalls
    result_if.ready = 1'b0;
    repeat (150) @(negedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        result_if.ready = 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        hold = idle_len();
        if (hold > 0) begin
          result_if.ready = 1'b0;
          repeat (hold) @(negedge clk);
        end
        result_if.ready = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    obbsat_in_t p;
    int         pick, span, rot_a, rot_b, delta;
    longint     base_x, base_y, ox, oy, reach;
    longint     ac, as, bc, bs, ahx, ahy, bhx, bhy;

    rst            = 1'b1;
    boxes_if.valid = 1'b0;
    boxes_if.data  = '0;
    sender_steady  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each axis separating, exact touching, extremes, odd trig
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 0, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 10 * ONE, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, -10 * ONE, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 0, 10 * ONE, ONE, ONE, UNIT, 0));
    // Box A with zero trig has null axes, so only B's axes can separate
    send_pair(box_pair(0, 0, ONE, ONE, 0, 0, 10 * ONE, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, 0, 0, 0, 10 * ONE, ONE, ONE, UNIT, 0));
    // Touching exactly, then one LSB apart
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 2 * ONE, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 2 * ONE + 1, 0, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 0, -2 * ONE, ONE, ONE, UNIT, 0));
    send_pair(box_pair(0, 0, ONE, ONE, UNIT, 0, 0, -2 * ONE - 1, ONE, ONE, UNIT, 0));
    // Quarter turns
    send_pair(box_pair(0, 0, 3 * ONE, ONE, 0, UNIT, 2 * ONE, 0, ONE, ONE, -UNIT, 0));
    send_pair(box_pair(0, 0, 3 * ONE, ONE, 0, UNIT, 10 * ONE, 0, ONE, ONE, -UNIT, 0));
    // 45 degrees
    send_pair(box_pair(0, 0, ONE, ONE, 11585, 11585, 2 * ONE, 0, ONE, ONE, 11585, 11585));
    send_pair(box_pair(0, 0, ONE, ONE, 11585, 11585, 3 * ONE, ONE, ONE, ONE, UNIT, 0));
    // Field extremes
    send_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(box_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, UNIT, 0,
                       -(64'sd1 <<< 31), -(64'sd1 <<< 31), 0, 0, UNIT, 0));
    send_pair(box_pair(32'h7FFFFFFF, -(64'sd1 <<< 31), 31'h7FFFFFFF, 31'h7FFFFFFF,
                       -32768, -32768, -(64'sd1 <<< 31), 32'h7FFFFFFF, 31'h7FFFFFFF,
                       31'h7FFFFFFF, -32768, -32768));
    send_pair(box_pair(32'h7FFFFFFF, 0, 31'h7FFFFFFF, 0, 32767, -32768,
                       -(64'sd1 <<< 31), 0, 0, 31'h7FFFFFFF, -32768, 32767));
    // Trig off the unit circle and alternating bit patterns
    send_pair(box_pair(ONE, -ONE, ONE, 2 * ONE, 12345, -777, 3 * ONE, ONE, ONE / 2, ONE,
                       -3, 20000));
    send_pair(box_pair(32'hAAAAAAAA, 32'h55555555, 31'h55555555, 31'h2AAAAAAA, 16'hAAAA,
                       16'h5555, 32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 31'h55555555,
                       16'h5555, 16'hAAAA));

    // Random mix
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 64 == 0)
        sender_steady = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // Raw bit patterns over the full field ranges
        p = box_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 35) begin
        // Quarter-turn boxes touching, or one LSB in or out
        rot_a = $urandom_range(0, 3);
        rot_b = $urandom_range(0, 3);
        quarter_trig(rot_a, ac, as);
        quarter_trig(rot_b, bc, bs);
        ahx   = $urandom_range(0, 1 << 20);
        ahy   = $urandom_range(0, 1 << 20);
        bhx   = $urandom_range(0, 1 << 20);
        bhy   = $urandom_range(0, 1 << 20);
        delta = $urandom_range(0, 2) - 1;
        base_x = longint'($urandom_range(0, 32'h7FFFFFFF)) - (64'sd1 <<< 30);
        base_y = longint'($urandom_range(0, 32'h7FFFFFFF)) - (64'sd1 <<< 30);
        if ($urandom_range(0, 1) == 0) begin
          reach = (rot_a % 2 == 0 ? ahx : ahy) + (rot_b % 2 == 0 ? bhx : bhy) + delta;
          ox = ($urandom_range(0, 1) == 0) ? reach : -reach;
          oy = 0;
        end else begin
          reach = (rot_a % 2 == 0 ? ahy : ahx) + (rot_b % 2 == 0 ? bhy : bhx) + delta;
          ox = 0;
          oy = ($urandom_range(0, 1) == 0) ? reach : -reach;
        end
        p = box_pair(base_x, base_y, ahx, ahy, ac, as, base_x + ox, base_y + oy,
                     bhx, bhy, bc, bs);
      end else begin
        // Rotated boxes placed close enough that any outcome is possible
        unit_trig($urandom_range(0, 3599), ac, as);
        unit_trig($urandom_range(0, 3599), bc, bs);
        if ($urandom_range(0, 7) == 0) begin
          ac = ac + $urandom_range(0, 6) - 3;
          bs = bs + $urandom_range(0, 6) - 3;
        end
        ahx  = $urandom_range(0, 1 << 20);
        ahy  = $urandom_range(0, 1 << 20);
        bhx  = $urandom_range(0, 1 << 20);
        bhy  = $urandom_range(0, 1 << 20);
        span = int'(ahx + ahy + bhx + bhy);
        ox   = longint'($urandom_range(0, 2 * span)) - span;
        oy   = longint'($urandom_range(0, 2 * span)) - span;
        base_x = longint'($urandom_range(0, 32'h7FFFFFFF)) - (64'sd1 <<< 30);
        base_y = longint'($urandom_range(0, 32'h7FFFFFFF)) - (64'sd1 <<< 30);
        p = box_pair(base_x, base_y, ahx, ahy, ac, as, base_x + ox, base_y + oy,
                     bhx, bhy, bc, bs);
      end
      send_pair(p);
    end
    boxes_if.valid = 1'b0;

    // Drain, then allow for anything still in the pipeline
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
